>>> rtl/core/bbq_pkg.sv
// ----------------------------------------------------------------------------
// bbq_pkg: shared types and codes of the bounded block queue
// Command and result beat structs, operation and status codes, register
// indexes and the reset value of the capacity register.
// ----------------------------------------------------------------------------
package bbq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int CAP_W         = 5;
    localparam int CFG_DATA_W    = 5;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CAPACITY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_OLDEST_MODE = 1'd1;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    localparam logic [2:0] ST_SUCCESS       = 3'd0;
    localparam logic [2:0] ST_INVALID_CFG   = 3'd1;
    localparam logic [2:0] ST_INVALID_BLOCK = 3'd2;
    localparam logic [2:0] ST_QUEUE_FULL    = 3'd3;
    localparam logic [2:0] ST_POP_EMPTY     = 3'd4;

    typedef struct packed {
        logic [1:0]         func;
        logic [15:0]        in_frame_count;
        logic signed [31:0] in_duration;
        logic [15:0]        in_data_length;
        logic [31:0]        in_data_handle;
    } t_cmd;

    typedef struct packed {
        logic [15:0]        frames;
        logic signed [31:0] duration;
        logic [15:0]        data_length;
        logic [31:0]        data_handle;
    } t_entry;

    typedef struct packed {
        logic [2:0]         status;
        logic               pop_valid;
        logic [15:0]        out_frame_count;
        logic signed [31:0] out_duration;
        logic [15:0]        out_data_length;
        logic [31:0]        out_data_handle;
        logic [4:0]         occupancy;
        logic               is_empty;
        logic               is_full;
        logic [31:0]        pushed_total;
        logic [31:0]        popped_total;
        logic [31:0]        dropped_total;
    } t_result;

endpackage

>>> rtl/core/bbq_store.sv
// ----------------------------------------------------------------------------
// bbq_store: descriptor storage of the bounded block queue
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module bbq_store #(
    parameter int DEPTH = bbq_pkg::DEPTH_DEFAULT,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_waddr,
    input  bbq_pkg::t_entry      i_wdata,
    input  logic [IDX_W-1:0]     i_raddr,
    output bbq_pkg::t_entry      o_rdata
);
    import bbq_pkg::*;

    t_entry r_mem [0:DEPTH-1];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/bounded_block_queue_overflow_policy.sv
// ----------------------------------------------------------------------------
// bounded_block_queue_overflow_policy: audio block descriptor FIFO
// The result beat is strobed on o_done in the cycle after start is taken.
// Throughput is one command per cycle, set by the single pass through the
// head/tail logic and the descriptor store; busy stays low and the receiver
// cannot stall. Synchronous active-low reset empties the queue, clears the
// counters and loads capacity 16, reject mode.
// ----------------------------------------------------------------------------
module bounded_block_queue_overflow_policy #(
    parameter int DEPTH = bbq_pkg::DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  bbq_pkg::t_cmd                       i_cmd,
    output logic                                o_done,
    output bbq_pkg::t_result                    o_result,
    input  logic                                i_cfg_we,
    input  logic [bbq_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bbq_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bbq_pkg::*;

    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W     = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
    localparam int DEPTH_CAP = (DEPTH > 31) ? 31 : DEPTH;

    logic [CAP_W-1:0] r_cap;
    logic             r_drop_mode;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CAP_W-1:0] r_count, n_count;
    logic [31:0]      r_pushed, n_pushed;
    logic [31:0]      r_popped, n_popped;
    logic [31:0]      r_dropped, n_dropped;
    logic [31:0]      r_rejected, n_rejected;
    logic             r_done;
    logic [2:0]       r_status, n_status;
    logic             r_pop_valid, n_pop_valid;

    logic             accept;
    logic [CAP_W-1:0] cap_eff;
    logic             blk_ok;
    logic             is_full_now;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] push_head;
    logic [CAP_W-1:0] push_count;
    logic [SUM_W-1:0] tail_sum;
    logic [IDX_W-1:0] tail;
    logic             mem_we;
    t_entry           wdata;
    t_entry           rdata;

    assign accept  = start && !busy;
    assign busy    = 1'b0;
    assign cap_eff = (r_cap > CAP_W'(DEPTH_CAP)) ? CAP_W'(DEPTH_CAP) : r_cap;

    assign blk_ok = (i_cmd.in_frame_count != 16'd0) && (i_cmd.in_data_length != 16'd0)
                    && (i_cmd.in_duration != 32'sd0) && !i_cmd.in_duration[31];
    assign is_full_now = (r_count >= cap_eff);

    assign head_inc = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + IDX_W'(1);

    always_comb begin
        push_head  = r_head;
        push_count = r_count;
        if (is_full_now) begin
            push_head  = head_inc;
            push_count = r_count - CAP_W'(1);
        end
        tail_sum = SUM_W'(push_head) + SUM_W'(push_count);
        if (tail_sum >= SUM_W'(DEPTH)) begin
            tail = IDX_W'(tail_sum - SUM_W'(DEPTH));
        end else begin
            tail = IDX_W'(tail_sum);
        end
    end

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_pushed    = r_pushed;
        n_popped    = r_popped;
        n_dropped   = r_dropped;
        n_rejected  = r_rejected;
        n_status    = ST_SUCCESS;
        n_pop_valid = 1'b0;
        mem_we      = 1'b0;
        if (accept) begin
            unique case (i_cmd.func)
                FUNC_PUSH: begin
                    priority if (cap_eff == '0) begin
                        n_status   = ST_INVALID_CFG;
                        n_rejected = r_rejected + 32'd1;
                    end else if (!blk_ok) begin
                        n_status   = ST_INVALID_BLOCK;
                        n_rejected = r_rejected + 32'd1;
                    end else if (is_full_now && !r_drop_mode) begin
                        n_status   = ST_QUEUE_FULL;
                        n_rejected = r_rejected + 32'd1;
                    end else begin
                        if (is_full_now) begin
                            n_dropped = r_dropped + 32'd1;
                        end
                        n_head   = push_head;
                        n_count  = push_count + CAP_W'(1);
                        n_pushed = r_pushed + 32'd1;
                        mem_we   = 1'b1;
                    end
                end
                FUNC_POP: begin
                    if (r_count == '0) begin
                        n_status = ST_POP_EMPTY;
                    end else begin
                        n_pop_valid = 1'b1;
                        n_head      = head_inc;
                        n_count     = r_count - CAP_W'(1);
                        n_popped    = r_popped + 32'd1;
                    end
                end
                FUNC_CLEAR: begin
                    n_head  = '0;
                    n_count = '0;
                end
                FUNC_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign wdata.frames      = i_cmd.in_frame_count;
    assign wdata.duration    = i_cmd.in_duration;
    assign wdata.data_length = i_cmd.in_data_length;
    assign wdata.data_handle = i_cmd.in_data_handle;

    bbq_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (tail),
        .i_wdata (wdata),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_drop_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QUEUE_CAPACITY:   r_cap       <= i_cfg_data;
                CFG_DROP_OLDEST_MODE: r_drop_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_pushed    <= '0;
            r_popped    <= '0;
            r_dropped   <= '0;
            r_rejected  <= '0;
            r_done      <= 1'b0;
            r_status    <= ST_SUCCESS;
            r_pop_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_pushed    <= n_pushed;
            r_popped    <= n_popped;
            r_dropped   <= n_dropped;
            r_rejected  <= n_rejected;
            r_done      <= accept;
            r_status    <= n_status;
            r_pop_valid <= n_pop_valid;
        end
    end

    assign o_done                   = r_done;
    assign o_result.status          = r_status;
    assign o_result.pop_valid       = r_pop_valid;
    assign o_result.out_frame_count = r_pop_valid ? rdata.frames : 16'd0;
    assign o_result.out_duration    = r_pop_valid ? rdata.duration : 32'sd0;
    assign o_result.out_data_length = r_pop_valid ? rdata.data_length : 16'd0;
    assign o_result.out_data_handle = r_pop_valid ? rdata.data_handle : 32'd0;
    assign o_result.occupancy       = r_count;
    assign o_result.is_empty        = (r_count == '0);
    assign o_result.is_full         = (cap_eff != '0) && (r_count >= cap_eff);
    assign o_result.pushed_total    = r_pushed;
    assign o_result.popped_total    = r_popped;
    assign o_result.dropped_total   = r_dropped;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= DEPTH)
        else $error("queue occupancy exceeds storage depth");

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy))
        else $error("result beat without an accepted command");

    a_pop_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.pop_valid) |-> (o_result.status == ST_SUCCESS))
        else $error("popped entry reported with a failing status");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_pushed != $past(r_pushed)))
        |-> $past(start && !busy && (i_cmd.func == FUNC_PUSH)))
        else $error("push counter moved without an accepted push");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the bounded block queue
// A clocked driver feeds command beats from a queue of pending commands with
// random idle bursts, and a clocked monitor checks every result beat against
// a command-level queue model run at the moment each command is taken. The run
// covers reset values, a short directed part and randomized phases over
// several capacity and overflow policy settings.
// ----------------------------------------------------------------------------
module testbench;
    import bbq_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 200000;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    t_cmd                  i_cmd      = '0;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_entry                   slot_q [DEPTH];
    logic [IDX_W-1:0]         head_q     = '0;
    logic [4:0]               count_q    = '0;
    logic [31:0]              pushed_q   = '0;
    logic [31:0]              popped_q   = '0;
    logic [31:0]              dropped_q  = '0;
    logic [31:0]              refused_q  = '0;
    logic [CAP_W-1:0]         cap_q      = CAP_RESET;
    logic                     drop_mode_q = 1'b0;

    t_cmd    pending_cmds[$];
    t_result expected_results[$];
    int      idle_pct      = 0;
    int      idle_left     = 0;
    int      error_count   = 0;
    int      beats_sent    = 0;
    int      beats_checked = 0;
    int      reg_writes    = 0;
    int      cycle_count   = 0;

    bounded_block_queue_overflow_policy uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_result predict_queue_result(input t_cmd c);
        t_result          r;
        logic [4:0]       cap;
        logic [IDX_W-1:0] tail;
        r = '0;
        r.status = ST_SUCCESS;
        cap = (cap_q > DEPTH) ? 5'(DEPTH) : cap_q;
        case (c.func)
            FUNC_PUSH: begin
                if (cap == 0) begin
                    r.status = ST_INVALID_CFG;
                    refused_q++;
                end else if (c.in_frame_count == 0 || c.in_duration == 0 ||
                             c.in_duration[31] || c.in_data_length == 0) begin
                    r.status = ST_INVALID_BLOCK;
                    refused_q++;
                end else if (count_q >= cap && !drop_mode_q) begin
                    r.status = ST_QUEUE_FULL;
                    refused_q++;
                end else begin
                    if (count_q >= cap) begin
                        head_q++;
                        count_q--;
                        dropped_q++;
                    end
                    tail = IDX_W'(5'(head_q) + count_q);
                    slot_q[tail] = {c.in_frame_count, c.in_duration,
                                    c.in_data_length, c.in_data_handle};
                    count_q++;
                    pushed_q++;
                end
            end
            FUNC_POP: begin
                if (count_q == 0) begin
                    r.status = ST_POP_EMPTY;
                end else begin
                    r.pop_valid       = 1'b1;
                    r.out_frame_count = slot_q[head_q].frames;
                    r.out_duration    = slot_q[head_q].duration;
                    r.out_data_length = slot_q[head_q].data_length;
                    r.out_data_handle = slot_q[head_q].data_handle;
                    head_q++;
                    count_q--;
                    popped_q++;
                end
            end
            FUNC_CLEAR: begin
                head_q  = '0;
                count_q = '0;
            end
            default: begin
            end
        endcase
        r.occupancy     = count_q;
        r.is_empty      = (count_q == 0);
        r.is_full       = (cap != 0 && count_q >= cap);
        r.pushed_total  = pushed_q;
        r.popped_total  = popped_q;
        r.dropped_total = dropped_q;
        return r;
    endfunction

    function automatic void add_cmd(input t_cmd c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    function automatic t_cmd make_command(input logic [1:0] func);
        t_cmd c;
        c.func           = func;
        c.in_frame_count = 16'($urandom);
        c.in_duration    = $urandom;
        c.in_data_length = 16'($urandom);
        c.in_data_handle = $urandom;
        return c;
    endfunction

    function automatic t_cmd make_push(input logic [15:0] frames, input logic [31:0] dur,
                                       input logic [15:0] len, input logic [31:0] handle);
        t_cmd c;
        c.func           = FUNC_PUSH;
        c.in_frame_count = frames;
        c.in_duration    = dur;
        c.in_data_length = len;
        c.in_data_handle = handle;
        return c;
    endfunction

    function automatic t_cmd good_push();
        return make_push(16'($urandom_range(1, 65535)), $urandom_range(1, 32'h7FFF_FFFF),
                         16'($urandom_range(1, 65535)), $urandom);
    endfunction

    function automatic t_cmd random_command(input int push_pct);
        t_cmd c;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < push_pct) begin
            if ($urandom_range(0, 99) < 85) begin
                c = good_push();
            end else begin
                c = make_command(FUNC_PUSH);
                case ($urandom_range(0, 3))
                    0: c.in_frame_count = '0;
                    1: c.in_duration = '0;
                    2: c.in_duration[31] = 1'b1;
                    default: c.in_data_length = '0;
                endcase
            end
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 88) begin
                c = make_command(FUNC_POP);
            end else if (pick < 95) begin
                c = make_command(FUNC_CLEAR);
            end else begin
                c = make_command(FUNC_NOP);
            end
        end
        return c;
    endfunction

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_QUEUE_CAPACITY) begin
            cap_q = data;
        end else begin
            drop_mode_q = data[0];
        end
        reg_writes++;
    endtask

    task automatic set_mode(input logic mode);
        logic [CFG_DATA_W-2:0] spare;
        spare = ($urandom_range(0, 1) == 1) ? '1 : '0;
        write_register(CFG_DROP_OLDEST_MODE, {spare, mode});
    endtask

    task automatic run_random_phase(input logic [4:0] cap, input logic mode, input int beats,
                                    input int push_pct, input int gap_pct);
        wait_idle();
        write_register(CFG_QUEUE_CAPACITY, cap);
        set_mode(mode);
        idle_pct = gap_pct;
        repeat (beats) add_cmd(random_command(push_pct));
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR: result beat %0d, %s: expected %h, got %h",
                     beats_checked, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (start && !busy) begin
            expected_results.insert(expected_results.size(), predict_queue_result(i_cmd));
            beats_sent++;
        end
        if (start && busy) begin
        end else if (idle_left != 0) begin
            start <= 1'b0;
            idle_left--;
        end else if (pending_cmds.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            idle_left = $urandom_range(0, 11);
        end else if (pending_cmds.size() != 0) begin
            start <= 1'b1;
            i_cmd <= pending_cmds[0];
            pending_cmds.delete(0);
        end else begin
            start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result want;
        t_result got;
        if (i_rst_n && o_done !== 1'b0) begin
            got = o_result;
            if (expected_results.size() == 0) begin
                note_mismatch("unexpected beat, status", '0, 32'(got.status));
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (got.status !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(got.status));
                if (got.pop_valid !== want.pop_valid)
                    note_mismatch("pop_valid", 32'(want.pop_valid), 32'(got.pop_valid));
                if (got.out_frame_count !== want.out_frame_count)
                    note_mismatch("out_frame_count", 32'(want.out_frame_count),
                                  32'(got.out_frame_count));
                if (got.out_duration !== want.out_duration)
                    note_mismatch("out_duration", want.out_duration, got.out_duration);
                if (got.out_data_length !== want.out_data_length)
                    note_mismatch("out_data_length", 32'(want.out_data_length),
                                  32'(got.out_data_length));
                if (got.out_data_handle !== want.out_data_handle)
                    note_mismatch("out_data_handle", want.out_data_handle,
                                  got.out_data_handle);
                if (got.occupancy !== want.occupancy)
                    note_mismatch("occupancy", 32'(want.occupancy), 32'(got.occupancy));
                if (got.is_empty !== want.is_empty)
                    note_mismatch("is_empty", 32'(want.is_empty), 32'(got.is_empty));
                if (got.is_full !== want.is_full)
                    note_mismatch("is_full", 32'(want.is_full), 32'(got.is_full));
                if (got.pushed_total !== want.pushed_total)
                    note_mismatch("pushed_total", want.pushed_total, got.pushed_total);
                if (got.popped_total !== want.popped_total)
                    note_mismatch("popped_total", want.popped_total, got.popped_total);
                if (got.dropped_total !== want.dropped_total)
                    note_mismatch("dropped_total", want.dropped_total, got.dropped_total);
            end
            beats_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: capacity 16, reject on full.
        add_cmd(make_command(FUNC_POP));
        add_cmd(make_command(FUNC_NOP));
        add_cmd(make_push(16'hFFFF, 32'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
        add_cmd(make_push(16'h0001, 32'h0000_0001, 16'h0001, 32'h0000_0000));
        add_cmd(make_push(16'h0000, 32'h0000_0100, 16'h0010, $urandom));
        add_cmd(make_push(16'h0010, 32'h0000_0000, 16'h0010, $urandom));
        add_cmd(make_push(16'h0010, 32'h8000_0000, 16'h0010, $urandom));
        add_cmd(make_push(16'h0010, 32'hFFFF_FFFF, 16'h0010, $urandom));
        add_cmd(make_push(16'h0010, 32'h0000_0100, 16'h0000, $urandom));
        add_cmd(make_command(FUNC_POP));
        add_cmd(make_command(FUNC_POP));
        add_cmd(make_command(FUNC_POP));
        add_cmd(good_push());
        add_cmd(good_push());
        add_cmd(make_command(FUNC_CLEAR));
        add_cmd(make_command(FUNC_POP));
        add_cmd(make_command(FUNC_CLEAR));

        // Full queue in reject mode, then drop-oldest, then capacity below occupancy.
        wait_idle();
        write_register(CFG_QUEUE_CAPACITY, 5'd2);
        set_mode(1'b0);
        repeat (3) add_cmd(good_push());
        wait_idle();
        set_mode(1'b1);
        add_cmd(good_push());
        wait_idle();
        write_register(CFG_QUEUE_CAPACITY, 5'd1);
        add_cmd(good_push());
        add_cmd(make_command(FUNC_POP));
        add_cmd(make_command(FUNC_POP));

        run_random_phase(5'd0,  1'b0, 40,  50, 20);
        run_random_phase(5'd4,  1'b0, 300, 55, 10);
        run_random_phase(5'd2,  1'b1, 300, 60, 40);
        run_random_phase(5'd31, 1'b0, 300, 65, 0);
        run_random_phase(5'd16, 1'b1, 300, 60, 25);
        repeat (10) add_cmd(good_push());
        run_random_phase(5'd1,  1'b1, 200, 50, 60);
        run_random_phase(5'd0,  1'b1, 30,  50, 15);
        run_random_phase(5'd17, 1'b1, 200, 60, 30);
        run_random_phase(5'($urandom_range(1, 16)), 1'($urandom_range(0, 1)), 250, 55, 0);
        wait_idle();

        $display("Summary: %0d command beats sent, %0d result beats checked, %0d reg writes.",
                 beats_sent, beats_checked, reg_writes);
        $display("Summary: %0d blocks stored, %0d popped, %0d dropped, %0d pushes refused.",
                 pushed_q, popped_q, dropped_q, refused_q);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bbq_pkg.sv
rtl/core/bbq_store.sv
rtl/core/bounded_block_queue_overflow_policy.sv
test/testbench.sv
